### sv/cbpd_pkg.sv
// ---------------------------------------------------------------------------
// cbpd_pkg : shared types for the covalent bond pair detector
// Atom record and the control word that rides the compare pipeline.
// ---------------------------------------------------------------------------
package cbpd_pkg;

    localparam int unsigned COORD_W  = 24;
    localparam int unsigned RADIUS_W = 12;
    localparam int unsigned SCALE_W  = 4;
    localparam int unsigned OUT_IDX_W = 5;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [RADIUS_W-1:0]       r;
    } atom_t;

    // vld: slot carries a step; cmp: stored atom is live; fin: last step of item
    typedef struct packed {
        logic vld;
        logic cmp;
        logic fin;
    } tag_t;

endpackage

### sv/covalent_bond_pair_detector_top.sv
// ---------------------------------------------------------------------------
// covalent_bond_pair_detector_top : covalent bond pair detector
// Reports bonded atom pairs within one residue by exact squared distance.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel: one atom per word. s_tuser = start of a new residue (the
//   atom becomes index 0). s_tdata holds x, y, z and radius.
//   m_ channel: one word per bonded pair (earlier index, current index),
//   m_tlast on the last pair caused by an atom. Atoms with no bond give
//   no word. cfg_ channel writes the bond scale in quarters (reset 5).
//   Scan: the stored atoms sit in a ring of MAX_ATOMS cells that turns
//   once per atom past one shared compare pipeline of three stages. An
//   atom arriving with the store full is accepted and dropped.
//   Output: a pair word is held back until the next hit or the end of the
//   scan, so the last pair of an atom comes out at the end of its scan.
//   Stall: a held m_ word freezes the ring and the compare pipeline;
//   s_tready stays low until the atom in work is finished.
//   Reset: atom count cleared, scale back to 5; stored atoms are not
//   cleared and are never read before written.
// ---------------------------------------------------------------------------
module covalent_bond_pair_detector_top #(
    parameter int unsigned MAX_ATOMS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // x_pos[23:0], y_pos[47:24], z_pos[71:48], radius[83:72]
    input  logic        s_tuser,   // start_residue
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // atom_index_a[4:0], atom_index_b[9:5]
    output logic        m_tlast,   // last_bond
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data   // bond_scale_quarters
);

    localparam int unsigned IW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int unsigned CW = $clog2(MAX_ATOMS + 1);
    localparam int unsigned OW = cbpd_pkg::OUT_IDX_W;

    // control
    logic                          busy_reg, issue_reg;
    logic [IW-1:0]                 step_reg;
    logic [CW-1:0]                 count_reg;
    logic [cbpd_pkg::SCALE_W-1:0]  scale_reg;
    cbpd_pkg::atom_t               probe_reg;

    // pending pair (held until we know whether it is the last one)
    logic          pend_v_reg;
    logic [OW-1:0] pend_a_reg;

    // output word
    logic          m_tvalid_reg;
    logic [OW-1:0] out_a_reg, out_b_reg;
    logic          out_last_reg;

    logic            adv, accept;
    logic [CW-1:0]   count_eff;
    cbpd_pkg::atom_t in_atom;
    cbpd_pkg::atom_t ring_q [MAX_ATOMS];
    cbpd_pkg::atom_t tail_d;
    cbpd_pkg::tag_t  iss_tag, res_tag;
    logic [IW-1:0]   res_idx;
    logic            res_hit;
    logic            shift_en;

    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = !busy_reg;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign count_eff = s_tuser ? '0 : count_reg;
    assign shift_en  = adv && issue_reg;

    assign in_atom.x = s_tdata[23:0];
    assign in_atom.y = s_tdata[47:24];
    assign in_atom.z = s_tdata[71:48];
    assign in_atom.r = s_tdata[83:72];

    // new atom slips into the ring as its index passes the head
    assign tail_d = (CW'(step_reg) == count_reg) ? probe_reg : ring_q[0];

    genvar k;
    generate
        for (k = 0; k < MAX_ATOMS; k++) begin : g_ring
            if (k == MAX_ATOMS - 1) begin : g_tail
                cbpd_cell u_cell (.aclk(aclk), .en(shift_en), .d(tail_d), .q(ring_q[k]));
            end else begin : g_mid
                cbpd_cell u_cell (.aclk(aclk), .en(shift_en), .d(ring_q[k+1]),
                                  .q(ring_q[k]));
            end
        end
    endgenerate

    always_comb begin
        iss_tag.vld = issue_reg;
        iss_tag.cmp = CW'(step_reg) < count_reg;
        iss_tag.fin = step_reg == IW'(MAX_ATOMS - 1);
    end

    cbpd_cmp #(.IW(IW)) u_cmp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_tag  (iss_tag),
        .in_idx  (step_reg),
        .probe   (probe_reg),
        .head    (ring_q[0]),
        .scale   (scale_reg),
        .out_tag (res_tag),
        .out_idx (res_idx),
        .hit     (res_hit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= cbpd_pkg::SCALE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            scale_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            issue_reg    <= 1'b0;
            step_reg     <= '0;
            count_reg    <= '0;
            pend_v_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_eff;
                if (count_eff < CW'(MAX_ATOMS)) begin
                    busy_reg  <= 1'b1;
                    issue_reg <= 1'b1;
                    step_reg  <= '0;
                end
            end
            if (shift_en) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == IW'(MAX_ATOMS - 1)) begin
                    issue_reg <= 1'b0;
                end
            end
            if (adv) begin
                m_tvalid_reg <= 1'b0;
                if (res_tag.vld && res_tag.cmp && res_hit) begin
                    pend_v_reg <= 1'b1;
                    if (pend_v_reg) begin
                        m_tvalid_reg <= 1'b1;
                    end
                end
                if (res_tag.vld && res_tag.fin) begin
                    busy_reg   <= 1'b0;
                    count_reg  <= count_reg + 1'b1;
                    pend_v_reg <= 1'b0;
                    if (pend_v_reg) begin
                        m_tvalid_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            probe_reg <= in_atom;
        end
        if (adv) begin
            if (res_tag.vld && res_tag.cmp && res_hit) begin
                pend_a_reg   <= OW'(res_idx);
                out_a_reg    <= pend_a_reg;
                out_b_reg    <= OW'(count_reg);
                out_last_reg <= 1'b0;
            end
            if (res_tag.vld && res_tag.fin) begin
                out_a_reg    <= pend_a_reg;
                out_b_reg    <= OW'(count_reg);
                out_last_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_b_reg, out_a_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> !pend_v_reg) else $error("pair left pending while idle");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ATOMS)) else $error("atom count overflow");
    a_busy_room: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> count_reg < CW'(MAX_ATOMS)) else $error("working with full store");
`endif

endmodule

### sv/cbpd_cell.sv
// ---------------------------------------------------------------------------
// cbpd_cell : one atom slot of the storage ring
// Takes its neighbor's atom, or at the tail a new one, when enabled.
// ---------------------------------------------------------------------------
module cbpd_cell (
    input  logic           aclk,
    input  logic           en,
    input  cbpd_pkg::atom_t d,
    output cbpd_pkg::atom_t q
);

    cbpd_pkg::atom_t atom_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            atom_reg <= d;
        end
    end

    assign q = atom_reg;

endmodule

### sv/cbpd_cmp.sv
// ---------------------------------------------------------------------------
// cbpd_cmp : pipelined distance versus bond limit test
// Three register stages: |diff| and rsum, squares and limit, sums and lim^2.
// ---------------------------------------------------------------------------
module cbpd_cmp #(
    parameter int unsigned IW = 5
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  cbpd_pkg::tag_t                    in_tag,
    input  logic [IW-1:0]                     in_idx,
    input  cbpd_pkg::atom_t                   probe,
    input  cbpd_pkg::atom_t                   head,
    input  logic [cbpd_pkg::SCALE_W-1:0]      scale,
    output cbpd_pkg::tag_t                    out_tag,
    output logic [IW-1:0]                     out_idx,
    output logic                              hit
);

    localparam int unsigned DW  = cbpd_pkg::COORD_W + 1;
    localparam int unsigned RSW = cbpd_pkg::RADIUS_W + 1;
    localparam int unsigned LW  = RSW + cbpd_pkg::SCALE_W;

    cbpd_pkg::tag_t tag1_reg, tag2_reg, tag3_reg;
    logic [IW-1:0]  idx1_reg, idx2_reg, idx3_reg;

    logic signed [DW-1:0] dx, dy, dz;
    logic [DW-1:0]        ax_reg, ay_reg, az_reg;
    logic [RSW-1:0]       rsum_reg;
    logic [2*DW-1:0]      sx_reg, sy_reg, sz_reg;
    logic [LW-1:0]        lim_reg;
    logic [2*DW+1:0]      d2_reg;
    logic [2*LW-1:0]      lim2_reg;

    always_comb begin
        dx = DW'(probe.x) - DW'(head.x);
        dy = DW'(probe.y) - DW'(head.y);
        dz = DW'(probe.z) - DW'(head.z);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end else if (en) begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            idx1_reg <= in_idx;
            idx2_reg <= idx1_reg;
            idx3_reg <= idx2_reg;
            ax_reg   <= dx[DW-1] ? DW'(-dx) : DW'(dx);
            ay_reg   <= dy[DW-1] ? DW'(-dy) : DW'(dy);
            az_reg   <= dz[DW-1] ? DW'(-dz) : DW'(dz);
            rsum_reg <= RSW'(probe.r) + RSW'(head.r);
            sx_reg   <= ax_reg * ax_reg;
            sy_reg   <= ay_reg * ay_reg;
            sz_reg   <= az_reg * az_reg;
            lim_reg  <= LW'(scale) * LW'(rsum_reg);
            d2_reg   <= (2*DW+2)'(sx_reg) + (2*DW+2)'(sy_reg) + (2*DW+2)'(sz_reg);
            lim2_reg <= lim_reg * lim_reg;
        end
    end

    // 16*d^2 < lim^2
    assign hit     = {d2_reg, 4'b0000} < (2*DW+6)'(lim2_reg);
    assign out_tag = tag3_reg;
    assign out_idx = idx3_reg;

endmodule

### test/cbpd_checker.sv
// ---------------------------------------------------------------------------
// cbpd_checker : bond pair checker
// Watches the atom, config and pair channels, predicts bonded pairs and
// compares each pair word with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module cbpd_checker #(
    parameter int unsigned MAX_ATOMS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    output int          fail_count,
    output int          pairs_pending
);

    typedef struct packed {
        logic [4:0] idx_a;
        logic [4:0] idx_b;
        logic       last;
    } pair_t;

    cbpd_pkg::atom_t atoms [MAX_ATOMS];
    int              n_atoms;
    logic [3:0]      scale_q;
    pair_t           pair_q[$];

    assign pairs_pending = pair_q.size();

    // exact bond test: 16*d^2 < (scale*(ra+rb))^2
    function automatic logic is_bonded(cbpd_pkg::atom_t p, cbpd_pkg::atom_t q,
                                       logic [3:0] s);
        longint dx, dy, dz;
        longint unsigned d2, lim;
        dx  = longint'(p.x) - longint'(q.x);
        dy  = longint'(p.y) - longint'(q.y);
        dz  = longint'(p.z) - longint'(q.z);
        d2  = dx * dx + dy * dy + dz * dz;
        lim = longint'(s) * (longint'(p.r) + longint'(q.r));
        return (16 * d2) < (lim * lim);
    endfunction

    task automatic add_atom(cbpd_pkg::atom_t a, logic start);
        int first;
        first = pair_q.size();
        if (start)
            n_atoms = 0;
        if (n_atoms >= MAX_ATOMS)
            return;
        for (int i = 0; i < n_atoms; i++) begin
            if (is_bonded(a, atoms[i], scale_q))
                pair_q.push_back('{idx_a: i[4:0], idx_b: n_atoms[4:0], last: 1'b0});
        end
        if (pair_q.size() > first)
            pair_q[pair_q.size() - 1].last = 1'b1;
        atoms[n_atoms] = a;
        n_atoms++;
    endtask

    always @(posedge aclk) begin
        cbpd_pkg::atom_t a;
        pair_t exp_p, got;
        if (!aresetn) begin
            n_atoms = 0;
            scale_q = cbpd_pkg::SCALE_RESET;
            pair_q.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{idx_a: m_tdata[4:0], idx_b: m_tdata[9:5], last: m_tlast};
                if (pair_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected pair a=%0d b=%0d last=%0b",
                                 got.idx_a, got.idx_b, got.last);
                end else begin
                    exp_p = pair_q.pop_front();
                    if (got !== exp_p) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("pair mismatch: exp a=%0d b=%0d last=%0b, got a=%0d b=%0d last=%0b",
                                     exp_p.idx_a, exp_p.idx_b, exp_p.last,
                                     got.idx_a, got.idx_b, got.last);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                a.x = s_tdata[23:0];
                a.y = s_tdata[47:24];
                a.z = s_tdata[71:48];
                a.r = s_tdata[83:72];
                add_atom(a, s_tuser);
            end
            if (cfg_valid && cfg_ready)
                scale_q = cfg_data;
        end
    end

endmodule

### test/tb_covalent_bond_pair_detector_top.sv
// ---------------------------------------------------------------------------
// tb_covalent_bond_pair_detector_top : bond pair detector testbench
// Drives residues of atoms with random gaps and output stalls, moves the
// bond scale through several settings while idle, and gives the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_covalent_bond_pair_detector_top;
    localparam int unsigned MAX_ATOMS = 32;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = '0;
    int          fail_count;
    int          pairs_pending;
    bit          stall_on = 1'b1;   // random output stalls enabled

    always #10 aclk = ~aclk;

    covalent_bond_pair_detector_top #(.MAX_ATOMS(MAX_ATOMS)) DUT (.*);

    cbpd_checker #(.MAX_ATOMS(MAX_ATOMS)) u_checker (.*);

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // output side: random stalls, with stall-free stretches
    always @(posedge aclk) begin
        if (!stall_on)
            m_tready <= 1'b1;
        else if ($urandom_range(0, 99) < 30)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) < 55);
    end

    // one atom word; holds until accepted, valid stays up for a back to back word
    task automatic send_atom(logic start, logic [23:0] x, logic [23:0] y,
                             logic [23:0] z, logic [11:0] r);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {4'b0, r, z, y, x};
        do @(posedge aclk); while (!s_tready);
    endtask

    // drop valid, wait until no atom is in work and every pair has come out
    task automatic wait_idle();
        int t;
        s_tvalid <= 1'b0;
        t = 0;
        do begin
            @(posedge aclk);
            t++;
        end while ((pairs_pending != 0 || !s_tready) && t < 200000);
        repeat (2 * MAX_ATOMS + 20) @(posedge aclk);
    endtask

    task automatic write_scale(logic [3:0] s);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= s;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // random atom near a base point so bonds really occur
    task automatic near_atom(logic start, int bx, int by, int bz, int spread);
        send_atom(start, 24'(bx + $urandom_range(0, 2 * spread) - spread),
                  24'(by + $urandom_range(0, 2 * spread) - spread),
                  24'(bz + $urandom_range(0, 2 * spread) - spread),
                  12'($urandom_range(300, 1800)));
    endtask

    initial begin
        int n, bx, by, bz, len;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: first atom, coordinate extremes, radius extremes
        send_atom(1'b1, 24'h000000, 24'h000000, 24'h000000, 12'd0);
        send_atom(1'b0, 24'h000000, 24'h000000, 24'h000000, 12'd0);   // d=0, lim=0
        send_atom(1'b0, 24'h000001, 24'h000000, 24'h000000, 12'd4095);
        send_atom(1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 12'd4095);
        send_atom(1'b0, 24'h800000, 24'h800000, 24'h800000, 12'd4095);
        send_atom(1'b0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 12'hAAA);
        send_atom(1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 12'h555);
        send_atom(1'b0, 24'h555555, 24'hAAAAAA, 24'h555555, 12'd1);
        send_atom(1'b0, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 12'd2000);
        // fill the residue past capacity: store full drops atoms
        for (int i = 9; i < MAX_ATOMS + 3; i++)
            near_atom(1'b0, 0, 0, 0, 1500);
        // new residue after full store
        near_atom(1'b1, 1000, -1000, 500, 800);
        near_atom(1'b0, 1000, -1000, 500, 800);

        write_scale(4'd0);   // nothing can bond
        for (int i = 0; i < 4; i++)
            near_atom(i == 0, 0, 0, 0, 200);
        write_scale(4'd15);
        for (int i = 0; i < 4; i++)
            near_atom(i == 0, 5000, 5000, 5000, 2000);

        // random residues; scale changes between them
        n = 0;
        while (n < 80) begin
            if ($urandom_range(0, 3) == 0)
                write_scale(4'($urandom_range(1, 15)));
            stall_on = ($urandom_range(0, 3) != 0);
            bx = $urandom_range(0, 16000000) - 8000000;
            by = $urandom_range(0, 16000000) - 8000000;
            bz = $urandom_range(0, 16000000) - 8000000;
            len = ($urandom_range(0, 9) == 0) ? MAX_ATOMS + 2 : $urandom_range(2, 12);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_atom(1'b0, 24'($urandom), 24'($urandom), 24'($urandom),
                              12'($urandom));
                else
                    near_atom(i == 0, bx, by, bz, $urandom_range(500, 3000));
                n++;
            end
        end
        write_scale(4'd5);
        stall_on = 1'b1;
        for (int i = 0; i < 6; i++)
            near_atom(i == 0, -3000, 2000, 0, 1200);

        wait_idle();
        if (fail_count == 0 && pairs_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #50ms;
        $display("FAIL");
        $finish;
    end
endmodule

### files.f
sv/cbpd_pkg.sv
sv/cbpd_cell.sv
sv/cbpd_cmp.sv
sv/covalent_bond_pair_detector_top.sv
test/cbpd_checker.sv
test/tb_covalent_bond_pair_detector_top.sv
